@@ sv/pbs_pkg.sv @@
package pbs_pkg;

    // Fixed widths of the channel fields
    localparam int FSEL_W = 2;
    localparam int COL_W  = 6;
    localparam int ROW_W  = 8;
    localparam int VAL_W  = 16;
    localparam int POS_W  = 24;

    // Request kinds
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic [FSEL_W-1:0]       field_sel;
        logic [COL_W-1:0]        grid_col;
        logic [ROW_W-1:0]        grid_row;
        logic signed [VAL_W-1:0] load_value;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] sample_value;
    } rsp_t;

endpackage

@@ sv/pbs_chan_if.sv @@
// Valid/ready channel carrying one payload per transaction
interface pbs_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/pbs_ram.sv @@
// Simple dual-read RAM: one write port, two registered read ports
module pbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // Write one entry, register both reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

@@ sv/periodic_bilinear_sampler_unit.sv @@
// Periodic bilinear sampler.
// req (sink): load transactions (req_type 0) write one grid entry of one field;
// sample transactions (req_type 1) give a fixed-point position that wraps on
// both axes, and each produces exactly one transaction on rsp (source) carrying
// the bilinear blend of the four surrounding entries, rounded to nearest.
// Loads and samples share one in-order pipeline, so a sample always sees every
// load accepted before it. An entry must be loaded before it is sampled.
// Throughput: one transaction per cycle while req.ready is high, loads and
// samples alike. The grid is held twice, in two RAMs with two read ports
// each, giving the four reads a sample needs in a single cycle; every load
// writes both copies. Each result passes stages s1 to s7 before it is queued.
// Results queue in a 16-entry buffer; req.ready stays high while fewer than 16
// samples are in flight or waiting, so a stalled receiver only throttles input
// once the buffer is full, and no result is ever dropped.
// Reset clears the pipeline valids and the result buffer; grid contents are
// left as they are and count as unknown until loaded.
module periodic_bilinear_sampler_unit #(
    parameter int NUM_FIELDS  = 4,
    parameter int GRID_COLS   = 64,
    parameter int GRID_ROWS   = 256,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    pbs_chan_if.sink       req,
    pbs_chan_if.source     rsp
);

    // Address layout {field, row, col}
    localparam int FAW   = (NUM_FIELDS > 2) ? 2 : 1;
    localparam int CAW   = $clog2(GRID_COLS);
    localparam int RAW   = $clog2(GRID_ROWS);
    localparam int AW    = FAW + RAW + CAW;
    localparam int DEPTH = 2 ** AW;

    // Position split and wrap
    localparam int IW    = pbs_pkg::POS_W - FRAC_BITS;
    localparam int UXW   = $clog2(2 ** IW + GRID_COLS);
    localparam int UYW   = $clog2(2 ** IW + GRID_ROWS);
    localparam int OFFX  = ((2 ** (IW - 1) + GRID_COLS - 1) / GRID_COLS) * GRID_COLS;
    localparam int OFFY  = ((2 ** (IW - 1) + GRID_ROWS - 1) / GRID_ROWS) * GRID_ROWS;
    localparam int MX    = (2 ** UXW) / GRID_COLS;
    localparam int MY    = (2 ** UYW) / GRID_ROWS;

    // Weights and accumulation
    localparam int ONE   = 2 ** FRAC_BITS;
    localparam int WW    = FRAC_BITS + 1;
    localparam int WPW   = 2 * WW;
    localparam int PW    = SAMPLE_BITS + WPW + 1;
    localparam int SW    = PW + 2;
    localparam int RND   = 2 ** (2 * FRAC_BITS - 1);

    // Result buffer
    localparam int QDEPTH = 16;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic vld;
        logic smp;
        logic fok;
        logic wen;
    } ctl_t;

    // Stage registers
    ctl_t                   s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, s4_ctl_reg;
    ctl_t                   s5_ctl_reg, s6_ctl_reg, s7_ctl_reg;
    logic [FAW-1:0]         s1_fsel_reg, s2_fsel_reg, s3_fsel_reg, s4_fsel_reg;
    logic [UXW-1:0]         s1_ux_reg, s2_ux_reg, s3_ux_reg;
    logic [UYW-1:0]         s1_uy_reg, s2_uy_reg, s3_uy_reg;
    logic [FRAC_BITS-1:0]   s1_fx_reg, s1_fy_reg;
    logic [AW-1:0]          s1_waddr_reg, s2_waddr_reg, s3_waddr_reg, s4_waddr_reg;
    logic [SAMPLE_BITS-1:0] s1_wdata_reg, s2_wdata_reg, s3_wdata_reg, s4_wdata_reg;
    logic [UXW-1:0]         s2_qx_reg, s3_pdx_reg;
    logic [UYW-1:0]         s2_qy_reg, s3_pdy_reg;
    logic [WPW-1:0]         s2_w_reg [4];
    logic [WPW-1:0]         s3_w_reg [4];
    logic [WPW-1:0]         s4_w_reg [4];
    logic [WPW-1:0]         s5_w_reg [4];
    logic [CAW-1:0]         s4_x0_reg, s4_x1_reg;
    logic [RAW-1:0]         s4_y0_reg, s4_y1_reg;
    logic signed [PW-1:0]   s6_p_reg [4];
    logic signed [PW:0]     s7_sa_reg, s7_sb_reg;

    // Result buffer registers
    logic [pbs_pkg::VAL_W-1:0] q_reg [QDEPTH];
    logic [QAW-1:0]            q_wptr_reg, q_rptr_reg;
    logic [QAW:0]              q_cnt_reg, pend_reg;

    // Combinational signals
    logic                      acc;
    ctl_t                      s1_ctl_next;
    logic signed [31:0]        ipx, ipy;
    logic [2*UXW-1:0]          prodx;
    logic [2*UYW-1:0]          prody;
    logic [WW-1:0]             wx0, wy0, wx1, wy1;
    logic [UXW-1:0]            rx, rxc;
    logic [UYW-1:0]            ry, ryc;
    logic [CAW-1:0]            x0_next;
    logic [RAW-1:0]            y0_next;
    logic [SAMPLE_BITS-1:0]    rd [4];
    logic signed [SW-1:0]      total;
    logic signed [SW-1:0]      shifted;
    logic [pbs_pkg::VAL_W-1:0] res_val;
    logic                      push, pop;
    logic                      ram_we;

    // Accept while the in-flight and queued samples leave room in the buffer
    assign req.ready = (pend_reg != (QAW+1)'(QDEPTH));
    assign acc       = req.valid && req.ready;

    // Classify the incoming transaction
    always_comb
    begin
        s1_ctl_next.vld = acc;
        s1_ctl_next.smp = (req.data.req_type == pbs_pkg::REQ_SAMPLE);
        s1_ctl_next.fok = (32'(req.data.field_sel) < NUM_FIELDS);
        s1_ctl_next.wen = acc && (req.data.req_type == pbs_pkg::REQ_LOAD)
                          && (32'(req.data.field_sel) < NUM_FIELDS)
                          && (32'(req.data.grid_col) < GRID_COLS)
                          && (32'(req.data.grid_row) < GRID_ROWS);
    end

    // Floor integer part of each coordinate
    assign ipx = 32'(req.data.pos_x) >>> FRAC_BITS;
    assign ipy = 32'(req.data.pos_y) >>> FRAC_BITS;

    // Reciprocal multiply for the wrap quotient
    assign prodx = {{UXW{1'b0}}, s1_ux_reg} * {{UXW{1'b0}}, UXW'(MX)};
    assign prody = {{UYW{1'b0}}, s1_uy_reg} * {{UYW{1'b0}}, UYW'(MY)};

    // Bilinear weights from the fraction bits
    assign wx1 = {1'b0, s1_fx_reg};
    assign wy1 = {1'b0, s1_fy_reg};
    assign wx0 = WW'(ONE) - wx1;
    assign wy0 = WW'(ONE) - wy1;

    // Remainder with one correction step
    assign rx      = s3_ux_reg - s3_pdx_reg;
    assign ry      = s3_uy_reg - s3_pdy_reg;
    assign rxc     = (rx >= UXW'(GRID_COLS)) ? rx - UXW'(GRID_COLS) : rx;
    assign ryc     = (ry >= UYW'(GRID_ROWS)) ? ry - UYW'(GRID_ROWS) : ry;
    assign x0_next = CAW'(rxc);
    assign y0_next = RAW'(ryc);

    // Grid copies: each one serves one row of the 2x2 neighbourhood
    assign ram_we = s4_ctl_reg.wen;

    pbs_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_ram_row0 (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (s4_waddr_reg),
        .wdata   (s4_wdata_reg),
        .raddr_a ({s4_fsel_reg, s4_y0_reg, s4_x0_reg}),
        .raddr_b ({s4_fsel_reg, s4_y0_reg, s4_x1_reg}),
        .rdata_a (rd[0]),
        .rdata_b (rd[1])
    );

    pbs_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_ram_row1 (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (s4_waddr_reg),
        .wdata   (s4_wdata_reg),
        .raddr_a ({s4_fsel_reg, s4_y1_reg, s4_x0_reg}),
        .raddr_b ({s4_fsel_reg, s4_y1_reg, s4_x1_reg}),
        .rdata_a (rd[2]),
        .rdata_b (rd[3])
    );

    // Final sum, round and floor shift
    assign total   = s7_sa_reg + s7_sb_reg + SW'(RND);
    assign shifted = total >>> (2 * FRAC_BITS);
    assign res_val = s7_ctl_reg.fok ? pbs_pkg::VAL_W'(shifted) : '0;

    // Result buffer handshake
    assign push                  = s7_ctl_reg.vld && s7_ctl_reg.smp;
    assign pop                   = rsp.valid && rsp.ready;
    assign rsp.valid             = (q_cnt_reg != '0);
    assign rsp.data.sample_value = q_reg[q_rptr_reg];

    // Advance pipeline valids and buffer bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
            s5_ctl_reg <= '0;
            s6_ctl_reg <= '0;
            s7_ctl_reg <= '0;
            q_wptr_reg <= '0;
            q_rptr_reg <= '0;
            q_cnt_reg  <= '0;
            pend_reg   <= '0;
        end
        else
        begin
            s1_ctl_reg <= s1_ctl_next;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
            s4_ctl_reg <= s3_ctl_reg;
            s5_ctl_reg <= s4_ctl_reg;
            s6_ctl_reg <= s5_ctl_reg;
            s7_ctl_reg <= s6_ctl_reg;
            if (push)
            begin
                q_wptr_reg <= q_wptr_reg + QAW'(1);
            end
            if (pop)
            begin
                q_rptr_reg <= q_rptr_reg + QAW'(1);
            end
            q_cnt_reg <= q_cnt_reg + (QAW+1)'(push) - (QAW+1)'(pop);
            pend_reg  <= pend_reg + (QAW+1)'(acc && s1_ctl_next.smp) - (QAW+1)'(pop);
        end
    end

    // Move payload down the pipeline
    always_ff @(posedge clk)
    begin
        // Capture the transaction
        s1_fsel_reg  <= FAW'(req.data.field_sel);
        s1_ux_reg    <= UXW'(ipx + 32'(OFFX));
        s1_uy_reg    <= UYW'(ipy + 32'(OFFY));
        s1_fx_reg    <= req.data.pos_x[FRAC_BITS-1:0];
        s1_fy_reg    <= req.data.pos_y[FRAC_BITS-1:0];
        s1_waddr_reg <= {FAW'(req.data.field_sel), RAW'(req.data.grid_row),
                         CAW'(req.data.grid_col)};
        s1_wdata_reg <= SAMPLE_BITS'(req.data.load_value);

        // Quotient and weights
        s2_fsel_reg  <= s1_fsel_reg;
        s2_ux_reg    <= s1_ux_reg;
        s2_uy_reg    <= s1_uy_reg;
        s2_qx_reg    <= prodx[2*UXW-1:UXW];
        s2_qy_reg    <= prody[2*UYW-1:UYW];
        s2_w_reg[0]  <= WPW'(wx0) * WPW'(wy0);
        s2_w_reg[1]  <= WPW'(wx1) * WPW'(wy0);
        s2_w_reg[2]  <= WPW'(wx0) * WPW'(wy1);
        s2_w_reg[3]  <= WPW'(wx1) * WPW'(wy1);
        s2_waddr_reg <= s1_waddr_reg;
        s2_wdata_reg <= s1_wdata_reg;

        // Quotient times grid size
        s3_fsel_reg  <= s2_fsel_reg;
        s3_ux_reg    <= s2_ux_reg;
        s3_uy_reg    <= s2_uy_reg;
        s3_pdx_reg   <= UXW'(32'(s2_qx_reg) * 32'(GRID_COLS));
        s3_pdy_reg   <= UYW'(32'(s2_qy_reg) * 32'(GRID_ROWS));
        s3_w_reg     <= s2_w_reg;
        s3_waddr_reg <= s2_waddr_reg;
        s3_wdata_reg <= s2_wdata_reg;

        // Wrapped indices and their +1 neighbours
        s4_fsel_reg  <= s3_fsel_reg;
        s4_x0_reg    <= x0_next;
        s4_y0_reg    <= y0_next;
        s4_x1_reg    <= (x0_next == CAW'(GRID_COLS - 1)) ? '0 : x0_next + CAW'(1);
        s4_y1_reg    <= (y0_next == RAW'(GRID_ROWS - 1)) ? '0 : y0_next + RAW'(1);
        s4_w_reg     <= s3_w_reg;
        s4_waddr_reg <= s3_waddr_reg;
        s4_wdata_reg <= s3_wdata_reg;

        // Hold weights alongside the RAM read
        s5_w_reg     <= s4_w_reg;

        // Weighted entries
        for (int i = 0; i < 4; i++)
        begin
            s6_p_reg[i] <= PW'($signed({1'b0, s5_w_reg[i]}) * $signed(rd[i]));
        end

        // Pair sums
        s7_sa_reg <= (PW+1)'(s6_p_reg[0]) + (PW+1)'(s6_p_reg[1]);
        s7_sb_reg <= (PW+1)'(s6_p_reg[2]) + (PW+1)'(s6_p_reg[3]);

        // Queue the result
        if (push)
        begin
            q_reg[q_wptr_reg] <= res_val;
        end
    end

endmodule

@@ sv/pbs_checker.sv @@
// Port-level checks on the sampler
module pbs_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_valid,
    input logic                      req_ready,
    input logic                      req_type,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input logic [pbs_pkg::VAL_W-1:0] rsp_value
);

    logic [15:0] out_cnt_reg;
    logic        smp_acc;
    logic        rsp_acc;

    assign smp_acc = req_valid && req_ready && (req_type == pbs_pkg::REQ_SAMPLE);
    assign rsp_acc = rsp_valid && rsp_ready;

    // Track samples accepted but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_cnt_reg <= '0;
        end
        else
        begin
            out_cnt_reg <= out_cnt_reg + 16'(smp_acc) - 16'(rsp_acc);
        end
    end

    // A stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp valid dropped while stalled");

    // A stalled result keeps its value
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_value))
        else $error("rsp value changed while stalled");

    // Every result answers an earlier sample
    a_rsp_owed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (out_cnt_reg != '0))
        else $error("result offered with no sample outstanding");

    // No result while reset is held
    a_rsp_reset: assert property (@(posedge clk)
        !rst_n |-> !rsp_valid)
        else $error("result offered during reset");

endmodule

bind periodic_bilinear_sampler_unit pbs_checker u_pbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_type  (req.data.req_type),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_value (rsp.data.sample_value)
);

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;

    localparam int NUM_FIELDS  = 4;
    localparam int GRID_COLS   = 64;
    localparam int GRID_ROWS   = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;

    localparam int  STORE_DEPTH = NUM_FIELDS * GRID_ROWS * GRID_COLS;
    localparam int  ONE_FRAC    = 1 << FRAC_BITS;
    // Number of grid periods either side of zero that a position can reach
    localparam int  X_WRAPS     = (1 << (pbs_pkg::POS_W - FRAC_BITS - 1)) / GRID_COLS;
    localparam int  Y_WRAPS     = (1 << (pbs_pkg::POS_W - FRAC_BITS - 1)) / GRID_ROWS;
    localparam int  CHUNK       = 175;
    localparam int  DRAIN_TAIL  = 16;
    localparam int  DIRECTED    = 23;

    typedef struct {
        logic kind;
        int   f;
        int   col;
        int   row;
        int   val;
        int   px;
        int   py;
        bit   typed;
        int   want;
    } step_t;

    typedef struct {
        int f;
        int cx;
        int cy;
    } cell_t;

    logic clk;
    logic rst_n;

    pbs_chan_if #(.payload_t(pbs_pkg::req_t)) req_if ();
    pbs_chan_if #(.payload_t(pbs_pkg::rsp_t)) rsp_if ();

    periodic_bilinear_sampler_unit #(
        .NUM_FIELDS  (NUM_FIELDS),
        .GRID_COLS   (GRID_COLS),
        .GRID_ROWS   (GRID_ROWS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow copy of the grids and the blends still owed by the block
    logic signed [SAMPLE_BITS-1:0]    grid_copy [STORE_DEPTH];
    logic signed [pbs_pkg::VAL_W-1:0] blend_q [$];
    cell_t                            live_cells [$];

    int fail_count    = 0;
    int items_sent    = 0;
    int src_idle_pct  = 0;
    int dst_stall_pct = 0;

    int idle_src [4] = '{0, 82, 0, 18};
    int idle_dst [4] = '{0, 0, 82, 18};

    // Directed transactions: wrap corners, period boundaries, extreme values
    step_t directed_steps [DIRECTED] = '{
        '{pbs_pkg::REQ_LOAD,   0,  0,   0,    100, 0, 0, 1'b0, 0},
        '{pbs_pkg::REQ_LOAD,   0,  1,   0,    200, 0, 0, 1'b0, 0},
        '{pbs_pkg::REQ_LOAD,   0,  0,   1,    300, 0, 0, 1'b0, 0},
        '{pbs_pkg::REQ_LOAD,   0,  1,   1,    400, 0, 0, 1'b0, 0},
        '{pbs_pkg::REQ_SAMPLE, 0,  0,   0,      0, 0, 0, 1'b1, 100},
        '{pbs_pkg::REQ_SAMPLE, 0,  0,   0,      0, 16384, 0, 1'b1, 100},
        '{pbs_pkg::REQ_SAMPLE, 0,  0,   0,      0, -16384, -65536, 1'b1, 100},
        '{pbs_pkg::REQ_SAMPLE, 0,  0,   0,      0, 128, 0, 1'b1, 150},
        '{pbs_pkg::REQ_SAMPLE, 0,  0,   0,      0, 128, 128, 1'b1, 250},
        '{pbs_pkg::REQ_SAMPLE, 0,  0,   0,      0, 255, 1, 1'b0, 0},
        '{pbs_pkg::REQ_SAMPLE, 0,  0,   0,      0, 'h55, 'hAA, 1'b0, 0},
        '{pbs_pkg::REQ_LOAD,   3, 63, 255,  32767, 0, 0, 1'b0, 0},
        '{pbs_pkg::REQ_LOAD,   3,  0, 255,  32767, 0, 0, 1'b0, 0},
        '{pbs_pkg::REQ_LOAD,   3, 63,   0,  32767, 0, 0, 1'b0, 0},
        '{pbs_pkg::REQ_LOAD,   3,  0,   0,  32767, 0, 0, 1'b0, 0},
        '{pbs_pkg::REQ_SAMPLE, 3,  0,   0,      0, -1, -1, 1'b1, 32767},
        '{pbs_pkg::REQ_SAMPLE, 3,  0,   0,      0, 8388607, 8388607, 1'b1, 32767},
        '{pbs_pkg::REQ_LOAD,   2,  0,   0, -32768, 0, 0, 1'b0, 0},
        '{pbs_pkg::REQ_LOAD,   2,  1,   0, -32768, 0, 0, 1'b0, 0},
        '{pbs_pkg::REQ_LOAD,   2,  0,   1, -32768, 0, 0, 1'b0, 0},
        '{pbs_pkg::REQ_LOAD,   2,  1,   1, -32768, 0, 0, 1'b0, 0},
        '{pbs_pkg::REQ_SAMPLE, 2,  0,   0,      0, -8388608, -8388608, 1'b1, -32768},
        '{pbs_pkg::REQ_SAMPLE, 2,  0,   0,      0, 'h80, 'h80, 1'b1, -32768}
    };

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Give up after a generous fixed time
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    // Reduce an integer grid coordinate into 0..size-1
    function automatic int wrap_index(input longint ip, input int size);
        return int'(((ip % size) + size) % size);
    endfunction

    // Bilinear blend of the four cells around a sample position
    function automatic logic signed [pbs_pkg::VAL_W-1:0] blend_at(input pbs_pkg::req_t r);
        longint ix, iy, fx, fy, acc;
        int     x0, x1, y0, y1, base;
        if (int'(r.field_sel) >= NUM_FIELDS)
            return '0;
        ix = longint'($signed(r.pos_x)) >>> FRAC_BITS;
        iy = longint'($signed(r.pos_y)) >>> FRAC_BITS;
        fx = longint'(r.pos_x[FRAC_BITS-1:0]);
        fy = longint'(r.pos_y[FRAC_BITS-1:0]);
        x0 = wrap_index(ix, GRID_COLS);
        y0 = wrap_index(iy, GRID_ROWS);
        x1 = (x0 + 1 == GRID_COLS) ? 0 : x0 + 1;
        y1 = (y0 + 1 == GRID_ROWS) ? 0 : y0 + 1;
        base = int'(r.field_sel) * GRID_ROWS;
        acc = (ONE_FRAC - fx) * (ONE_FRAC - fy) * longint'(grid_copy[(base + y0) * GRID_COLS + x0])
            + fx * (ONE_FRAC - fy) * longint'(grid_copy[(base + y0) * GRID_COLS + x1])
            + (ONE_FRAC - fx) * fy * longint'(grid_copy[(base + y1) * GRID_COLS + x0])
            + fx * fy * longint'(grid_copy[(base + y1) * GRID_COLS + x1]);
        acc += longint'(1) << (2 * FRAC_BITS - 1);
        return pbs_pkg::VAL_W'(acc >>> (2 * FRAC_BITS));
    endfunction

    function automatic logic signed [pbs_pkg::VAL_W-1:0] pick_value();
        unique case ($urandom_range(0, 11))
            0:       return {1'b0, {(pbs_pkg::VAL_W-1){1'b1}}};
            1:       return {1'b1, {(pbs_pkg::VAL_W-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return pbs_pkg::VAL_W'($urandom);
        endcase
    endfunction

    function automatic int pick_frac();
        unique case ($urandom_range(0, 7))
            0:       return 0;
            1:       return ONE_FRAC - 1;
            default: return int'($urandom_range(0, ONE_FRAC - 1));
        endcase
    endfunction

    // Offer one transaction, hold it until accepted, then update the shadow state
    task automatic send_request(input pbs_pkg::req_t item, input bit typed,
                                input logic signed [pbs_pkg::VAL_W-1:0] typed_value);
        int                               addr;
        logic signed [pbs_pkg::VAL_W-1:0] owed;
        while (int'($urandom_range(99)) < src_idle_pct)
        begin
            @(negedge clk);
            req_if.valid <= 1'b0;
        end
        @(negedge clk);
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        do @(posedge clk); while (!req_if.ready);
        items_sent++;
        if (item.req_type == pbs_pkg::REQ_LOAD)
        begin
            // Out-of-range loads leave the grid untouched
            if (int'(item.field_sel) < NUM_FIELDS && int'(item.grid_col) < GRID_COLS
                && int'(item.grid_row) < GRID_ROWS)
            begin
                addr = (int'(item.field_sel) * GRID_ROWS + int'(item.grid_row)) * GRID_COLS
                     + int'(item.grid_col);
                grid_copy[addr] = item.load_value[SAMPLE_BITS-1:0];
            end
        end
        else
        begin
            owed    = typed ? typed_value : blend_at(item);
            blend_q = {blend_q, owed};
        end
    endtask

    task automatic send_load(input int f, input int col, input int row,
                             input logic signed [pbs_pkg::VAL_W-1:0] value);
        pbs_pkg::req_t item;
        item.req_type   = pbs_pkg::REQ_LOAD;
        item.field_sel  = pbs_pkg::FSEL_W'(f);
        item.grid_col   = pbs_pkg::COL_W'(col);
        item.grid_row   = pbs_pkg::ROW_W'(row);
        item.load_value = value;
        item.pos_x      = pbs_pkg::POS_W'($urandom);
        item.pos_y      = pbs_pkg::POS_W'($urandom);
        send_request(item, 1'b0, '0);
    endtask

    // Sample inside cell (cx, cy), shifted by a random number of grid periods
    task automatic send_sample(input int f, input int cx, input int cy);
        pbs_pkg::req_t item;
        int            kx, ky;
        kx = int'($urandom_range(0, 2 * X_WRAPS - 1)) - X_WRAPS;
        ky = int'($urandom_range(0, 2 * Y_WRAPS - 1)) - Y_WRAPS;
        item.req_type   = pbs_pkg::REQ_SAMPLE;
        item.field_sel  = pbs_pkg::FSEL_W'(f);
        item.grid_col   = pbs_pkg::COL_W'($urandom);
        item.grid_row   = pbs_pkg::ROW_W'($urandom);
        item.load_value = pbs_pkg::VAL_W'($urandom);
        item.pos_x      = pbs_pkg::POS_W'((cx + GRID_COLS * kx) * ONE_FRAC + pick_frac());
        item.pos_y      = pbs_pkg::POS_W'((cy + GRID_ROWS * ky) * ONE_FRAC + pick_frac());
        send_request(item, 1'b0, '0);
    endtask

    // Drop valid and wait until every owed blend has come back or the guard runs out
    task automatic drain_results();
        int guard;
        @(negedge clk);
        req_if.valid <= 1'b0;
        for (guard = 0; guard < 20000 && blend_q.size() != 0; guard++)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    // Receiver: stall at random according to the current phase
    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_if.ready <= (int'($urandom_range(99)) >= dst_stall_pct);
        end
    end

    // Compare each result transaction with the oldest owed blend
    always @(posedge clk)
    begin
        logic signed [pbs_pkg::VAL_W-1:0] want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (blend_q.size() == 0)
            begin
                $error("sample_value: expected none, got %0d", rsp_if.data.sample_value);
                fail_count++;
            end
            else
            begin
                want = blend_q.pop_front();
                if (rsp_if.data.sample_value !== want)
                begin
                    $error("sample_value: expected %0d, got %0d",
                           want, rsp_if.data.sample_value);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        pbs_pkg::req_t item;
        step_t         s;
        cell_t         c;
        int            f, cx, cy, x1, y1, pick, n;

        rst_n        = 1'b1;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        #1;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table with no idling
        for (int i = 0; i < DIRECTED; i++)
        begin
            s = directed_steps[i];
            item.req_type   = s.kind;
            item.field_sel  = pbs_pkg::FSEL_W'(s.f);
            item.grid_col   = pbs_pkg::COL_W'(s.col);
            item.grid_row   = pbs_pkg::ROW_W'(s.row);
            item.load_value = pbs_pkg::VAL_W'(s.val);
            item.pos_x      = pbs_pkg::POS_W'(s.px);
            item.pos_y      = pbs_pkg::POS_W'(s.py);
            send_request(item, s.typed, pbs_pkg::VAL_W'(s.want));
        end

        // Random phases; let the block empty out before each one
        for (int ph = 0; ph < 8; ph++)
        begin
            drain_results();
            src_idle_pct  = idle_src[ph % 4];
            dst_stall_pct = idle_dst[ph % 4];
            while (items_sent < DIRECTED + (ph + 1) * CHUNK)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6 || live_cells.size() == 0)
                begin
                    // Fill a whole cell, then sample inside it
                    f  = $urandom_range(0, NUM_FIELDS - 1);
                    cx = $urandom_range(0, GRID_COLS - 1);
                    cy = $urandom_range(0, GRID_ROWS - 1);
                    x1 = (cx + 1 == GRID_COLS) ? 0 : cx + 1;
                    y1 = (cy + 1 == GRID_ROWS) ? 0 : cy + 1;
                    send_load(f, cx, cy, pick_value());
                    send_load(f, x1, cy, pick_value());
                    send_load(f, cx, y1, pick_value());
                    send_load(f, x1, y1, pick_value());
                    n = $urandom_range(1, 3);
                    repeat (n) send_sample(f, cx, cy);
                    c          = '{f, cx, cy};
                    live_cells = {live_cells, c};
                    if (live_cells.size() > 64)
                        void'(live_cells.pop_front());
                end
                else if (pick < 8)
                begin
                    // Revisit a cell filled earlier, possibly since overwritten
                    c = live_cells[$urandom_range(0, live_cells.size() - 1)];
                    send_sample(c.f, c.cx, c.cy);
                end
                else
                    send_load($urandom_range(0, NUM_FIELDS - 1),
                              $urandom_range(0, GRID_COLS - 1),
                              $urandom_range(0, GRID_ROWS - 1), pick_value());
            end
        end

        drain_results();
        if (blend_q.size() != 0)
        begin
            $error("sample_value: %0d results never arrived", blend_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
